@@ hw/rtl/ajb_pkg.sv @@
package ajb_pkg;

	// Get outcome codes
	localparam logic [1:0] OUTC_EMPTY = 2'd0;
	localparam logic [1:0] OUTC_BELOW = 2'd1;
	localparam logic [1:0] OUTC_PLAY  = 2'd2;
	localparam logic [1:0] OUTC_SKIP  = 2'd3;

	// Field widths
	localparam int SEQ_W = 32;
	localparam int SMP_W = 16;
	localparam int LEN_W = 7;
	localparam int CNT_W = 32;
	localparam int MIN_W = 8;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic close;
		logic scan_clr;
		logic scan_rd;
		logic put_dec;
		logic copy_rd;
		logic stg_clr;
		logic get_silence;
		logic get_dec;
		logic get_len;
		logic emit_ld;
	} ajb_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic put_late;
		logic scan_issued;
		logic scan_done;
		logic discard;
		logic copy_done;
		logic copy_issued;
		logic play;
		logic out_free;
		logic emit_last;
		logic is_get;
	} ajb_stat_t;

endpackage

@@ hw/rtl/audio_jitter_buffer_unit.sv @@
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   req_type sequence_req sample_in last_sample
//                                          frames_requested
// out      output     out_valid/out_stall sample_out last_out copied_count outcome
//                                          counters occupancy
// cfg      input      cfg_valid/cfg_ready cfg_data (min_buffered_packets)
//
// A put sample that does not close its packet does not stall the input. A closing put
// stalls the input for a sequential slot scan through the sequence memory read port,
// then a copy of the staged samples into the slot; a late put skips the scan and the
// copy, a discarded one skips the copy.
// A get scans the slots (not when silent), then returns each word through S_EMIT_RD and
// S_EMIT_LD, waiting while out_stall is high; the output register holds a word under
// stall. Reset clears slot valid bits at once; no clearing pass is needed.
module audio_jitter_buffer_unit #(
	parameter int MAX_PACKETS = 128,
	parameter int MAX_FRAMES  = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              req_type,
	input  logic [ajb_pkg::SEQ_W-1:0]         sequence_req,
	input  logic signed [ajb_pkg::SMP_W-1:0]  sample_in,
	input  logic                              last_sample,
	input  logic [ajb_pkg::LEN_W-1:0]         frames_requested,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [ajb_pkg::SMP_W-1:0]  sample_out,
	output logic                              last_out,
	output logic [ajb_pkg::LEN_W-1:0]         copied_count,
	output logic [1:0]                        outcome,
	output logic [ajb_pkg::CNT_W-1:0]         received_total,
	output logic [ajb_pkg::CNT_W-1:0]         lost_total,
	output logic [ajb_pkg::CNT_W-1:0]         late_total,
	output logic [ajb_pkg::CNT_W-1:0]         reordered_total,
	output logic [7:0]                        occupancy,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ajb_pkg::MIN_W-1:0]         cfg_data
);
	import ajb_pkg::*;

	ajb_cmd_t  cmd;
	ajb_stat_t stat;

	assign cfg_ready = 1'b1;

	ajb_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.req_type    (req_type),
		.last_sample (last_sample),
		.in_stall    (in_stall),
		.stat        (stat),
		.cmd         (cmd)
	);

	ajb_dp #(
		.MAX_PACKETS (MAX_PACKETS),
		.MAX_FRAMES  (MAX_FRAMES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg_valid        (cfg_valid),
		.cfg_data         (cfg_data),
		.req_type         (req_type),
		.sequence_req     (sequence_req),
		.sample_in        (sample_in),
		.frames_requested (frames_requested),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.sample_out       (sample_out),
		.last_out         (last_out),
		.copied_count     (copied_count),
		.outcome          (outcome),
		.received_total   (received_total),
		.lost_total       (lost_total),
		.late_total       (late_total),
		.reordered_total  (reordered_total),
		.occupancy        (occupancy)
	);

endmodule

@@ hw/rtl/ajb_ctrl.sv @@
module ajb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              req_type,
	input  logic              last_sample,
	output logic              in_stall,
	input  ajb_pkg::ajb_stat_t stat,
	output ajb_pkg::ajb_cmd_t  cmd
);
	import ajb_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_CLOSE, S_SCAN, S_PUT_DEC, S_COPY,
		S_GET, S_GET_DEC, S_LEN, S_EMIT_RD, S_EMIT_LD
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	// Decode commands and next state
	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (req_type) state_d = S_GET;
					else if (last_sample) state_d = S_CLOSE;
				end
			end
			S_CLOSE: begin
				cmd.close = 1'b1;
				if (stat.put_late) begin
					cmd.stg_clr = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.scan_clr = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = !stat.scan_issued;
				if (stat.scan_done) state_d = stat.is_get ? S_GET_DEC : S_PUT_DEC;
			end
			S_PUT_DEC: begin
				cmd.put_dec = 1'b1;
				if (stat.discard) begin
					cmd.stg_clr = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_COPY;
				end
			end
			S_COPY: begin
				cmd.copy_rd = !stat.copy_issued;
				if (stat.copy_done) begin
					cmd.stg_clr = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_GET: begin
				if (stat.play) begin
					cmd.scan_clr = 1'b1;
					state_d = S_SCAN;
				end else begin
					cmd.get_silence = 1'b1;
					state_d = S_EMIT_RD;
				end
			end
			S_GET_DEC: begin
				cmd.get_dec = 1'b1;
				state_d = S_LEN;
			end
			S_LEN: begin
				cmd.get_len = 1'b1;
				state_d = S_EMIT_RD;
			end
			S_EMIT_RD: begin
				state_d = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				if (stat.out_free) begin
					cmd.emit_ld = 1'b1;
					state_d = stat.emit_last ? S_IDLE : S_EMIT_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hw/rtl/ajb_dp.sv @@
module ajb_dp #(
	parameter int MAX_PACKETS = 128,
	parameter int MAX_FRAMES  = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ajb_pkg::ajb_cmd_t                 cmd,
	output ajb_pkg::ajb_stat_t                stat,
	input  logic                              cfg_valid,
	input  logic [ajb_pkg::MIN_W-1:0]         cfg_data,
	input  logic                              req_type,
	input  logic [ajb_pkg::SEQ_W-1:0]         sequence_req,
	input  logic signed [ajb_pkg::SMP_W-1:0]  sample_in,
	input  logic [ajb_pkg::LEN_W-1:0]         frames_requested,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [ajb_pkg::SMP_W-1:0]  sample_out,
	output logic                              last_out,
	output logic [ajb_pkg::LEN_W-1:0]         copied_count,
	output logic [1:0]                        outcome,
	output logic [ajb_pkg::CNT_W-1:0]         received_total,
	output logic [ajb_pkg::CNT_W-1:0]         lost_total,
	output logic [ajb_pkg::CNT_W-1:0]         late_total,
	output logic [ajb_pkg::CNT_W-1:0]         reordered_total,
	output logic [7:0]                        occupancy
);
	import ajb_pkg::*;

	localparam int PAW  = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
	localparam int FAW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int SW   = $clog2(MAX_PACKETS + 1);
	localparam int CW   = $clog2(MAX_FRAMES + 1);
	localparam int SAW  = $clog2(MAX_PACKETS * MAX_FRAMES);
	localparam int CMPW = (SW > MIN_W) ? SW : MIN_W;
	localparam int OCCW = (SW > 8) ? SW : 8;

	// Memories
	logic [SEQ_W-1:0]  seq_mem [MAX_PACKETS];
	logic [LEN_W-1:0]  len_mem [MAX_PACKETS];
	logic [SMP_W-1:0]  smp_mem [MAX_PACKETS * MAX_FRAMES];
	logic [SMP_W-1:0]  stg_mem [MAX_FRAMES];
	logic [MAX_PACKETS-1:0] valid_q;

	// Control and counter registers
	logic [MIN_W-1:0] min_q;
	logic [CW-1:0]    stg_cnt_q;
	logic [SEQ_W-1:0] nps_q;
	logic             started_q;
	logic [SW-1:0]    stored_q;
	logic [CNT_W-1:0] rcv_q, lost_q, late_q, reo_q;
	logic             is_get_q;
	logic [SEQ_W-1:0] seq_q;
	logic [LEN_W-1:0] n_q;

	// Scan state
	logic [PAW:0]     idx_q;
	logic             rdv_s1, vld_s1;
	logic [PAW-1:0]   rdidx_s1;
	logic [SEQ_W-1:0] rdseq_s1;
	logic             mfound_q, lfound_q, ffound_q;
	logic [PAW-1:0]   midx_q, lidx_q, fidx_q;
	logic [SEQ_W-1:0] lseq_q, hseq_q;

	// Copy and playout state
	logic [PAW-1:0]   tgt_q;
	logic [LEN_W-1:0] k_q;
	logic             cpv_s1;
	logic [FAW-1:0]   cpk_s1;
	logic [SMP_W-1:0] cpd_s1;
	logic [LEN_W-1:0] len_rd_q;
	logic [SMP_W-1:0] smp_rd_q;
	logic [LEN_W-1:0] copied_q;
	logic [1:0]       outc_q;
	logic             out_valid_q;

	// Output word registers
	logic [LEN_W-1:0] copied_out_q;
	logic [1:0]       outc_out_q;
	logic [CNT_W-1:0] rcv_out_q, lost_out_q, late_out_q, reo_out_q;
	logic [7:0]       occ_out_q;

	logic [SEQ_W-1:0] key;
	logic             full;
	logic [PAW-1:0]   put_tgt, get_tgt;
	logic [LEN_W-1:0] n_clamp;
	logic [SAW-1:0]   rd_addr, wr_addr;
	logic [CMPW-1:0]  stored_cmp, min_cmp;
	logic [OCCW-1:0]  occ_ext;

	assign key        = is_get_q ? nps_q : seq_q;
	assign full       = (stored_q >= SW'(MAX_PACKETS));
	assign put_tgt    = mfound_q ? midx_q : (full ? lidx_q : fidx_q);
	assign get_tgt    = mfound_q ? midx_q : lidx_q;
	assign stored_cmp = CMPW'(stored_q);
	assign min_cmp    = CMPW'(min_q);
	assign occ_ext    = OCCW'(stored_q);
	assign rd_addr    = SAW'(tgt_q) * SAW'(MAX_FRAMES) + SAW'(k_q);
	assign wr_addr    = SAW'(tgt_q) * SAW'(MAX_FRAMES) + SAW'(cpk_s1);

	// Clamp the requested length to one through the packet size
	always_comb begin
		if (frames_requested == '0) n_clamp = LEN_W'(1);
		else if (frames_requested > LEN_W'(MAX_FRAMES)) n_clamp = LEN_W'(MAX_FRAMES);
		else n_clamp = frames_requested;
	end

	// Status toward the controller
	always_comb begin
		stat.put_late    = started_q && (seq_q < nps_q);
		stat.scan_issued = (idx_q == (PAW+1)'(MAX_PACKETS));
		stat.scan_done   = stat.scan_issued && !rdv_s1;
		stat.discard     = !mfound_q && full && (seq_q < lseq_q);
		stat.copy_issued = (k_q >= LEN_W'(stg_cnt_q));
		stat.copy_done   = stat.copy_issued && !cpv_s1;
		stat.play        = started_q && (stored_q != '0) && (stored_cmp >= min_cmp);
		stat.out_free    = !out_valid_q || !out_stall;
		stat.emit_last   = (k_q == n_q - LEN_W'(1));
		stat.is_get      = is_get_q;
	end

	// Memory ports
	always_ff @(posedge clk) begin
		if (cmd.accept && !req_type && (stg_cnt_q < CW'(MAX_FRAMES)))
			stg_mem[stg_cnt_q[FAW-1:0]] <= sample_in;
		if (cmd.put_dec && !stat.discard) begin
			seq_mem[put_tgt] <= seq_q;
			len_mem[put_tgt] <= LEN_W'(stg_cnt_q);
		end
		if (cmd.scan_rd) rdseq_s1 <= seq_mem[idx_q[PAW-1:0]];
		if (cmd.copy_rd) cpd_s1 <= stg_mem[k_q[FAW-1:0]];
		if (cpv_s1) smp_mem[wr_addr] <= cpd_s1;
		len_rd_q <= len_mem[get_tgt];
		smp_rd_q <= smp_mem[rd_addr];
	end

	// Payload registers of the scan and copy paths
	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			rdidx_s1 <= idx_q[PAW-1:0];
			vld_s1   <= valid_q[idx_q[PAW-1:0]];
		end
		if (cmd.copy_rd) cpk_s1 <= k_q[FAW-1:0];
		if (cmd.accept) begin
			is_get_q <= req_type;
			seq_q    <= sequence_req;
			n_q      <= n_clamp;
		end
		// Load the whole output word, hold it while stalled
		if (cmd.emit_ld) begin
			sample_out   <= (k_q < copied_q) ? smp_rd_q : '0;
			last_out     <= stat.emit_last;
			copied_out_q <= copied_q;
			outc_out_q   <= outc_q;
			rcv_out_q    <= rcv_q;
			lost_out_q   <= lost_q;
			late_out_q   <= late_q;
			reo_out_q    <= reo_q;
			occ_out_q    <= occ_ext[7:0];
		end
	end

	// Control state, counters and scan results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= '0;
			stg_cnt_q   <= '0;
			nps_q       <= '0;
			started_q   <= 1'b0;
			stored_q    <= '0;
			rcv_q       <= '0;
			lost_q      <= '0;
			late_q      <= '0;
			reo_q       <= '0;
			valid_q     <= '0;
			idx_q       <= '0;
			rdv_s1      <= 1'b0;
			cpv_s1      <= 1'b0;
			mfound_q    <= 1'b0;
			lfound_q    <= 1'b0;
			ffound_q    <= 1'b0;
			midx_q      <= '0;
			lidx_q      <= '0;
			fidx_q      <= '0;
			lseq_q      <= '0;
			hseq_q      <= '0;
			tgt_q       <= '0;
			k_q         <= '0;
			copied_q    <= '0;
			outc_q      <= OUTC_EMPTY;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) min_q <= cfg_data;

			// Stage put samples
			if (cmd.accept && !req_type && (stg_cnt_q < CW'(MAX_FRAMES)))
				stg_cnt_q <= stg_cnt_q + CW'(1);
			if (cmd.stg_clr) stg_cnt_q <= '0;

			// Close a put: count, start, drop late words
			if (cmd.close) begin
				rcv_q <= rcv_q + CNT_W'(1);
				if (!started_q) begin
					started_q <= 1'b1;
					nps_q     <= seq_q;
				end
				if (stat.put_late) late_q <= late_q + CNT_W'(1);
			end

			// Scan slots one per cycle
			rdv_s1 <= cmd.scan_rd;
			if (cmd.scan_clr) begin
				idx_q    <= '0;
				mfound_q <= 1'b0;
				lfound_q <= 1'b0;
				ffound_q <= 1'b0;
			end else if (cmd.scan_rd) begin
				idx_q <= idx_q + (PAW+1)'(1);
			end
			if (rdv_s1) begin
				if (vld_s1 && (rdseq_s1 == key) && !mfound_q) begin
					mfound_q <= 1'b1;
					midx_q   <= rdidx_s1;
				end
				if (vld_s1 && (!lfound_q || (rdseq_s1 < lseq_q))) begin
					lidx_q <= rdidx_s1;
					lseq_q <= rdseq_s1;
				end
				if (vld_s1 && (!lfound_q || (rdseq_s1 > hseq_q))) hseq_q <= rdseq_s1;
				if (vld_s1) lfound_q <= 1'b1;
				if (!vld_s1 && !ffound_q) begin
					ffound_q <= 1'b1;
					fidx_q   <= rdidx_s1;
				end
			end

			// Store a put
			if (cmd.put_dec) begin
				if (lfound_q && (seq_q < hseq_q)) reo_q <= reo_q + CNT_W'(1);
				if (!stat.discard) begin
					valid_q[put_tgt] <= 1'b1;
					if (!mfound_q && !full) stored_q <= stored_q + SW'(1);
				end
				tgt_q <= put_tgt;
				k_q   <= '0;
			end

			// Copy staging into the slot
			cpv_s1 <= cmd.copy_rd;
			if (cmd.copy_rd) k_q <= k_q + LEN_W'(1);

			// Pick the packet to play
			if (cmd.get_dec) begin
				tgt_q            <= get_tgt;
				valid_q[get_tgt] <= 1'b0;
				stored_q         <= stored_q - SW'(1);
				if (mfound_q) begin
					outc_q <= OUTC_PLAY;
					nps_q  <= nps_q + SEQ_W'(1);
				end else begin
					outc_q <= OUTC_SKIP;
					if (nps_q < lseq_q) begin
						lost_q <= lost_q + (lseq_q - nps_q);
						nps_q  <= lseq_q + SEQ_W'(1);
					end else begin
						lost_q <= lost_q + CNT_W'(1);
						nps_q  <= nps_q + SEQ_W'(1);
					end
				end
			end
			if (cmd.get_len) begin
				copied_q <= (len_rd_q < n_q) ? len_rd_q : n_q;
				k_q      <= '0;
			end
			if (cmd.get_silence) begin
				outc_q   <= (started_q && (stored_q != '0)) ? OUTC_BELOW : OUTC_EMPTY;
				copied_q <= '0;
				k_q      <= '0;
			end

			// Emit one word, hold while stalled
			if (cmd.emit_ld) begin
				out_valid_q <= 1'b1;
				k_q         <= k_q + LEN_W'(1);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign copied_count    = copied_out_q;
	assign outcome         = outc_out_q;
	assign received_total  = rcv_out_q;
	assign lost_total      = lost_out_q;
	assign late_total      = late_out_q;
	assign reordered_total = reo_out_q;
	assign occupancy       = occ_out_q;

endmodule
